/* src/tsl_pkg.sv */
package tsl_pkg;

  // Field widths
  localparam int SLW  = 18;   // slope, Q3.14
  localparam int POSW = 24;   // position, 1/16 micron
  localparam int GRW  = 8;    // grain count
  localparam int CFGW = 48;   // widest config register
  localparam int CIW  = 2;    // config index
  localparam int LNW  = 20;   // link number
  localparam int PIW  = 10;   // partner index
  localparam int PSW  = 9;    // points sum
  localparam int DSW  = 36;   // squared slope distance
  localparam int QSH  = 14;   // slope fraction bits

  // Input opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  // Config register indexes
  localparam logic [CIW-1:0] CFG_MIN_POINTS   = 2'd0;
  localparam logic [CIW-1:0] CFG_MIN_SLOPE_SQ = 2'd1;
  localparam logic [CIW-1:0] CFG_SLOPE_TOL_SQ = 2'd2;
  localparam logic [CIW-1:0] CFG_POS_TOL_SQ   = 2'd3;

  // Link slope divider: dividend is |d| << 14, 25 + 14 bits
  localparam int DIV_STEPS = 39;
  localparam logic signed [SLW-1:0] SLOPE_MAX = 18'sh1FFFF;
  localparam logic signed [SLW-1:0] SLOPE_MIN = 18'sh20000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_SCAN,
    ST_DIV,
    ST_CLOSE
  } state_t;

  // One stored segment
  typedef struct packed {
    logic [8:0]  q;    // {grains, valid}
    logic [47:0] zp;   // {plane_z, pos_z}
    logic [47:0] xy;   // {pos_y, pos_x}
    logic [35:0] sl;   // {slope_y, slope_x}
  } tab_ent_t;

endpackage

/* src/tsl_if.sv */
interface tsl_req_if;
  import tsl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic                   side;
  logic                   seg_valid;
  logic [GRW-1:0]         grains;
  logic signed [SLW-1:0]  slope_x;
  logic signed [SLW-1:0]  slope_y;
  logic signed [POSW-1:0] pos_x;
  logic signed [POSW-1:0] pos_y;
  logic signed [POSW-1:0] pos_z;
  logic signed [POSW-1:0] plane_z;

  modport source(output valid, opcode, side, seg_valid, grains, slope_x, slope_y,
                 pos_x, pos_y, pos_z, plane_z, input ready);
  modport sink(input valid, opcode, side, seg_valid, grains, slope_x, slope_y,
               pos_x, pos_y, pos_z, plane_z, output ready);
endinterface

interface tsl_rsp_if;
  import tsl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   is_match;
  logic                   last;
  logic                   overflow;
  logic [LNW-1:0]         link_number;
  logic [PIW-1:0]         partner_index;
  logic [PSW-1:0]         points_sum;
  logic signed [POSW-1:0] link_pos_x;
  logic signed [POSW-1:0] link_pos_y;
  logic signed [POSW-1:0] link_pos_z;
  logic signed [SLW-1:0]  link_slope_x;
  logic signed [SLW-1:0]  link_slope_y;
  logic [DSW-1:0]         slope_dist_sq;

  modport source(output valid, is_match, last, overflow, link_number, partner_index,
                 points_sum, link_pos_x, link_pos_y, link_pos_z, link_slope_x,
                 link_slope_y, slope_dist_sq, input ready);
  modport sink(input valid, is_match, last, overflow, link_number, partner_index,
               points_sum, link_pos_x, link_pos_y, link_pos_z, link_slope_x,
               link_slope_y, slope_dist_sq, output ready);
endinterface

/* src/track_segment_linker_top.sv */
// Clear and store are accepted in ST_IDLE; store writes one table entry unless full.
// A probe passes ST_SETUP1 and ST_SETUP2, then, if usable, scans table_count entries
// at one per cycle, paused while a match is taken, through a 5-stage read/compare
// pipeline; each taken match waits in ST_DIV for both dividers and a free output
// register, then scanning resumes after it. The input is not ready until ST_IDLE.
// Synchronous reset clears table_count, the pair counter and config; table undefined.
module track_segment_linker_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_MATCHES = 63
) (
  input  logic                      clk,
  input  logic                      rst,
  tsl_req_if.sink                   req,
  tsl_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [tsl_pkg::CIW-1:0]   cfg_index,
  input  logic [tsl_pkg::CFGW-1:0]  cfg_data
);
  import tsl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = 6;

  typedef struct packed {
    logic [AW-1:0]   idx;
    logic [GRW-1:0]  gr;
    logic [POSW-1:0] x;
    logic [POSW-1:0] y;
    logic [POSW-1:0] z;
  } pass_t;

  // Config registers
  logic [7:0]  min_points;
  logic [35:0] min_slope_sq;
  logic [35:0] slope_tol_sq;
  logic [47:0] pos_tol_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_points   <= '0;
      min_slope_sq <= '0;
      slope_tol_sq <= '0;
      pos_tol_sq   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_POINTS:   min_points   <= cfg_data[7:0];
        CFG_MIN_SLOPE_SQ: min_slope_sq <= cfg_data[35:0];
        CFG_SLOPE_TOL_SQ: slope_tol_sq <= cfg_data[35:0];
        CFG_POS_TOL_SQ:   pos_tol_sq   <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // Control state
  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_ptr;
  logic [NW-1:0] n_out;
  logic          over;
  logic [LNW-1:0] pair_cnt;
  logic          vr, v1, v2, v3, v4;
  logic          match4;

  logic accept, is_probe, issue, hit, take, drop, out_free, pipe_busy;
  logic emit_match, emit_close;
  logic ov;
  logic dv_busy_x, dv_busy_y;

  assign accept    = req.valid && req.ready;
  assign is_probe  = (req.opcode == OP_PROBE);
  assign out_free  = !ov || rsp.ready;
  assign pipe_busy = vr || v1 || v2 || v3 || v4;

  // Probe segment
  logic                   p_side, p_valid, p_ok;
  logic [GRW-1:0]         p_gr;
  logic signed [SLW-1:0]  p_sx, p_sy;
  logic signed [POSW-1:0] p_px, p_py, p_pz, p_plane;
  logic signed [35:0]     p_sqx, p_sqy;
  logic signed [42:0]     p_prx, p_pry;
  logic signed [29:0]     p_pex, p_pey;

  // Next state and pipeline control
  always_comb begin
    state_next = state;
    hit        = (state == ST_SCAN) && v4 && match4;
    take       = hit && (n_out != NW'(MAX_MATCHES));
    drop       = hit && (n_out == NW'(MAX_MATCHES));
    issue      = (state == ST_SCAN) && p_ok && (rd_ptr < count) && !take;
    emit_match = 1'b0;
    emit_close = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && is_probe) state_next = ST_SETUP1;
      end
      ST_SETUP1: state_next = ST_SETUP2;
      ST_SETUP2: state_next = ST_SCAN;
      ST_SCAN: begin
        if (take) begin
          state_next = ST_DIV;
        end else if ((!p_ok || rd_ptr >= count) && !pipe_busy) begin
          state_next = ST_CLOSE;
        end
      end
      ST_DIV: begin
        if (!dv_busy_x && !dv_busy_y && out_free) begin
          emit_match = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          emit_close = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  // Segment table
  tab_ent_t mem [TABLE_DEPTH];
  tab_ent_t rd_ent;
  tab_ent_t wr_ent;
  logic     mem_we;

  assign mem_we = accept && (req.opcode == OP_STORE) && (count < CW'(TABLE_DEPTH));
  assign wr_ent = '{q:  {req.grains, req.seg_valid},
                    zp: {req.plane_z, req.pos_z},
                    xy: {req.pos_y, req.pos_x},
                    sl: {req.slope_y, req.slope_x}};

  always_ff @(posedge clk) begin
    if (mem_we) mem[count[AW-1:0]] <= wr_ent;
    rd_ent <= mem[rd_ptr[AW-1:0]];
  end

  // Stage 1: products from the table entry
  logic signed [SLW-1:0]  w_sx, w_sy;
  logic signed [POSW-1:0] w_z, w_plane;
  logic signed [SLW:0]    dsx, dsy;
  logic signed [POSW:0]   wdz, pdz;

  assign w_sx    = signed'(rd_ent.sl[17:0]);
  assign w_sy    = signed'(rd_ent.sl[35:18]);
  assign w_z     = signed'(rd_ent.zp[23:0]);
  assign w_plane = signed'(rd_ent.zp[47:24]);
  assign dsx     = (SLW+1)'(p_sx) - (SLW+1)'(w_sx);
  assign dsy     = (SLW+1)'(p_sy) - (SLW+1)'(w_sy);
  assign wdz     = (POSW+1)'(w_plane) - (POSW+1)'(w_z);
  assign pdz     = (POSW+1)'(p_plane) - (POSW+1)'(p_pz);

  logic [AW-1:0]      ridx;
  pass_t              s1, s2, s3, s4;
  logic               s1_wv;
  logic signed [35:0] s1_wsqx, s1_wsqy;
  logic signed [37:0] s1_dsqx, s1_dsqy;
  logic signed [42:0] s1_wpx, s1_wpy;

  always_ff @(posedge clk) begin
    s1      <= '{idx: ridx, gr: rd_ent.q[8:1], x: rd_ent.xy[23:0],
                 y: rd_ent.xy[47:24], z: rd_ent.zp[23:0]};
    s1_wv   <= rd_ent.q[0];
    s1_wsqx <= 36'(w_sx) * 36'(w_sx);
    s1_wsqy <= 36'(w_sy) * 36'(w_sy);
    s1_dsqx <= 38'(dsx) * 38'(dsx);
    s1_dsqy <= 38'(dsy) * 38'(dsy);
    s1_wpx  <= 43'(wdz) * 43'(w_sx);
    s1_wpy  <= 43'(wdz) * 43'(w_sy);
  end

  // Stage 2: extrapolations and differences
  logic signed [42:0] w_rx, w_ry;
  logic signed [29:0] w_ex, w_ey;
  logic signed [36:0] w_sqsum;

  assign w_rx    = (s1_wpx + 43'sd8192) >>> QSH;
  assign w_ry    = (s1_wpy + 43'sd8192) >>> QSH;
  assign w_ex    = 30'(signed'(s1.x)) + 30'(w_rx);
  assign w_ey    = 30'(signed'(s1.y)) + 30'(w_ry);
  assign w_sqsum = 37'(s1_wsqx) + 37'(s1_wsqy);

  logic               s2_wok;
  logic signed [37:0] s2_ds;
  logic signed [30:0] s2_a1, s2_b1, s2_a2, s2_b2;

  always_ff @(posedge clk) begin
    s2     <= s1;
    s2_wok <= s1_wv && (s1.gr >= min_points) && (w_sqsum >= 37'(min_slope_sq));
    s2_ds  <= s1_dsqx + s1_dsqy;
    s2_a1  <= 31'(p_pex) - 31'(signed'(s1.x));
    s2_b1  <= 31'(p_pey) - 31'(signed'(s1.y));
    s2_a2  <= 31'(w_ex) - 31'(p_px);
    s2_b2  <= 31'(w_ey) - 31'(p_py);
  end

  // Stage 3: squared mismatches
  logic               s3_wok;
  logic signed [37:0] s3_ds;
  logic signed [61:0] s3_qa1, s3_qb1, s3_qa2, s3_qb2;

  always_ff @(posedge clk) begin
    s3     <= s2;
    s3_wok <= s2_wok;
    s3_ds  <= s2_ds;
    s3_qa1 <= 62'(s2_a1) * 62'(s2_a1);
    s3_qb1 <= 62'(s2_b1) * 62'(s2_b1);
    s3_qa2 <= 62'(s2_a2) * 62'(s2_a2);
    s3_qb2 <= 62'(s2_b2) * 62'(s2_b2);
  end

  // Stage 4: tolerance compares
  logic signed [61:0] d1, d2;
  logic [DSW-1:0]     s4_ds;

  assign d1 = s3_qa1 + s3_qb1;
  assign d2 = s3_qa2 + s3_qb2;

  always_ff @(posedge clk) begin
    s4     <= s3;
    s4_ds  <= DSW'(s3_ds);
    match4 <= s3_wok && (s3_ds < 38'(slope_tol_sq)) &&
              (d1 < 62'(pos_tol_sq)) && (d2 < 62'(pos_tol_sq));
  end

  // Probe setup: own extrapolation and usability
  logic signed [42:0] p_rx, p_ry;

  assign p_rx = (p_prx + 43'sd8192) >>> QSH;
  assign p_ry = (p_pry + 43'sd8192) >>> QSH;

  always_ff @(posedge clk) begin
    if (accept && is_probe) begin
      p_side  <= req.side;
      p_valid <= req.seg_valid;
      p_gr    <= req.grains;
      p_sx    <= req.slope_x;
      p_sy    <= req.slope_y;
      p_px    <= req.pos_x;
      p_py    <= req.pos_y;
      p_pz    <= req.pos_z;
      p_plane <= req.plane_z;
    end
    if (state == ST_SETUP1) begin
      p_sqx <= 36'(p_sx) * 36'(p_sx);
      p_sqy <= 36'(p_sy) * 36'(p_sy);
      p_prx <= 43'(pdz) * 43'(p_sx);
      p_pry <= 43'(pdz) * 43'(p_sy);
    end
    if (state == ST_SETUP2) begin
      p_pex <= 30'(p_px) + 30'(p_rx);
      p_pey <= 30'(p_py) + 30'(p_ry);
      p_ok  <= p_valid && (p_gr >= min_points) &&
               ((37'(p_sqx) + 37'(p_sqy)) >= 37'(min_slope_sq));
    end
  end

  // Captured match
  pass_t          m;
  logic [DSW-1:0] m_ds;

  always_ff @(posedge clk) begin
    if (take) begin
      m    <= s4;
      m_ds <= s4_ds;
    end
  end

  // Link slope dividers, started on the captured pair
  logic signed [POSW:0]  num_x, num_y, den_z;
  logic signed [SLW-1:0] ls_x, ls_y;

  assign num_x = (POSW+1)'(p_px) - (POSW+1)'(signed'(s4.x));
  assign num_y = (POSW+1)'(p_py) - (POSW+1)'(signed'(s4.y));
  assign den_z = (POSW+1)'(p_pz) - (POSW+1)'(signed'(s4.z));

  tsl_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (take),
    .num   (num_x),
    .den   (den_z),
    .busy  (dv_busy_x),
    .quo   (ls_x)
  );

  tsl_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (take),
    .num   (num_y),
    .den   (den_z),
    .busy  (dv_busy_y),
    .quo   (ls_y)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rd_ptr   <= '0;
      n_out    <= '0;
      over     <= 1'b0;
      pair_cnt <= '0;
      vr       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (req.opcode == OP_CLEAR)) count <= '0;
      if (mem_we) count <= count + 1'b1;
      if (accept && is_probe) begin
        rd_ptr <= '0;
        n_out  <= '0;
        over   <= 1'b0;
      end
      if (issue) rd_ptr <= rd_ptr + 1'b1;
      if (take) rd_ptr <= CW'(s4.idx) + 1'b1;
      if (drop) over <= 1'b1;
      if (emit_match) begin
        n_out <= n_out + 1'b1;
        if (pair_cnt != '1) pair_cnt <= pair_cnt + 1'b1;
      end
      vr <= issue;
      v1 <= vr && !take;
      v2 <= v1 && !take;
      v3 <= v2 && !take;
      v4 <= v3 && !take;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) ridx <= rd_ptr[AW-1:0];
  end

  // Output register
  logic                   o_match, o_last, o_over;
  logic [LNW-1:0]         o_lnum;
  logic [PIW-1:0]         o_pidx;
  logic [PSW-1:0]         o_psum;
  logic signed [POSW-1:0] o_x, o_y, o_z;
  logic signed [SLW-1:0]  o_sx, o_sy;
  logic [DSW-1:0]         o_ds;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit_match || emit_close) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_match) begin
      o_match <= 1'b1;
      o_last  <= 1'b0;
      o_over  <= 1'b0;
      o_lnum  <= pair_cnt;
      o_pidx  <= PIW'(m.idx);
      o_psum  <= PSW'(p_gr) + PSW'(m.gr);
      o_x     <= p_side ? signed'(m.x) : p_px;
      o_y     <= p_side ? signed'(m.y) : p_py;
      o_z     <= p_side ? signed'(m.z) : p_pz;
      o_sx    <= ls_x;
      o_sy    <= ls_y;
      o_ds    <= m_ds;
    end else if (emit_close) begin
      o_match <= 1'b0;
      o_last  <= 1'b1;
      o_over  <= over;
      o_lnum  <= '0;
      o_pidx  <= '0;
      o_psum  <= '0;
      o_x     <= '0;
      o_y     <= '0;
      o_z     <= '0;
      o_sx    <= '0;
      o_sy    <= '0;
      o_ds    <= '0;
    end
  end

  assign rsp.valid         = ov;
  assign rsp.is_match      = o_match;
  assign rsp.last          = o_last;
  assign rsp.overflow      = o_over;
  assign rsp.link_number   = o_lnum;
  assign rsp.partner_index = o_pidx;
  assign rsp.points_sum    = o_psum;
  assign rsp.link_pos_x    = o_x;
  assign rsp.link_pos_y    = o_y;
  assign rsp.link_pos_z    = o_z;
  assign rsp.link_slope_x  = o_sx;
  assign rsp.link_slope_y  = o_sy;
  assign rsp.slope_dist_sq = o_ds;

endmodule

/* src/tsl_div.sv */
// Restoring divider for the link slope: (num * 2^14) / den, truncated toward
// zero and saturated to Q3.14. One quotient bit per cycle.
module tsl_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [tsl_pkg::POSW:0]   num,
  input  logic signed [tsl_pkg::POSW:0]   den,
  output logic                            busy,
  output logic signed [tsl_pkg::SLW-1:0]  quo
);
  import tsl_pkg::*;

  localparam int MW = POSW + 1;
  localparam int CNW = $clog2(DIV_STEPS + 1);

  logic [DIV_STEPS-1:0] dvd;
  logic [MW-1:0]        dmag;
  logic [MW-1:0]        rem;
  logic [CNW-1:0]       cnt;
  logic                 neg;
  logic                 den_zero;
  logic                 num_pos;
  logic                 num_neg;

  logic [MW-1:0] num_mag;
  logic [MW-1:0] den_mag;
  logic [MW:0]   rem_sh;
  logic          qbit;

  assign num_mag = num[MW-1] ? MW'(-num) : MW'(num);
  assign den_mag = den[MW-1] ? MW'(-den) : MW'(den);
  assign rem_sh  = {rem, dvd[DIV_STEPS-1]};
  assign qbit    = (rem_sh >= {1'b0, dmag});

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNW'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNW'(1)) busy <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= DIV_STEPS'({num_mag, {QSH{1'b0}}});
      dmag     <= den_mag;
      rem      <= '0;
      neg      <= num[MW-1] ^ den[MW-1];
      den_zero <= (den == '0);
      num_pos  <= !num[MW-1] && (num != '0);
      num_neg  <= num[MW-1];
    end else if (busy) begin
      rem <= qbit ? MW'(rem_sh - {1'b0, dmag}) : MW'(rem_sh);
      dvd <= {dvd[DIV_STEPS-2:0], qbit};
    end
  end

  // Sign and saturation
  always_comb begin
    if (den_zero) begin
      quo = num_pos ? SLOPE_MAX : (num_neg ? SLOPE_MIN : '0);
    end else if (!neg) begin
      quo = (dvd > DIV_STEPS'(SLOPE_MAX)) ? SLOPE_MAX : SLW'(dvd);
    end else begin
      quo = (dvd > DIV_STEPS'(18'h20000)) ? SLOPE_MIN : SLW'(-dvd);
    end
  end

endmodule
